/* hw/rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and codes for the protobuf string field extractor.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int unsigned FIELD_W   = 29;  // field number width
    localparam int unsigned VARINT_W  = 32;  // decoded varint width
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned VI_IDX_W  = 3;   // byte index inside a varint
    localparam int unsigned PHASE_W   = 2;

    // Result queue: worst case one byte pushes two results.
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QAW       = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [FIELD_W-1:0] WANTED_FIELD_RST = FIELD_W'(1);

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_KEY     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SKIPVAR = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LEN     = 2'd2;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR   = 2'd3;

    // Protobuf wire types of interest
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    // Last byte index of a 32-bit varint (five bytes)
    localparam logic [VI_IDX_W-1:0] VI_LAST = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] text_byte;
        logic              last_of_run;
    } t_result;

endpackage

/* hw/rtl/protobuf_string_field_extractor_top.sv */
// ----------------------------------------------------------------------------
// protobuf_string_field_extractor_top - wanted length-delimited field extractor
// Results: a byte's results are registered into the result queue, in order.
// Throughput: one byte per cycle while o_stall is low; an end-of-message byte may give two results.
// Reset: synchronous, active low; clears parser, result queue, wanted_field=1.
// ----------------------------------------------------------------------------
module protobuf_string_field_extractor_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [pse_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                               i_end_of_message,
    // result output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [pse_pkg::KIND_W-1:0]         o_kind,
    output logic [pse_pkg::BYTE_W-1:0]         o_text_byte,
    output logic                               o_last_of_run,
    // configuration write channel (wanted_field)
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pse_pkg::FIELD_W-1:0]        i_cfg_data
);

    // ------------------------------------------------------------------
    // Parser state. Every accepted byte is folded into this state by the
    // next-state logic below; its results go straight
    // into a small result queue, which decouples the two channels.
    // ------------------------------------------------------------------
    logic [pse_pkg::FIELD_W-1:0]   r_wanted_field;
    logic [pse_pkg::PHASE_W-1:0]   r_phase,   n_phase;
    logic [pse_pkg::VARINT_W-1:0]  r_acc,     n_acc;     // varint being built
    logic [pse_pkg::VI_IDX_W-1:0]  r_vi_idx,  n_vi_idx;  // byte index in varint
    logic [pse_pkg::VARINT_W-1:0]  r_rem,     n_rem;     // payload bytes left
    logic                          r_is_wanted, n_is_wanted;
    logic                          r_err,     n_err;     // error latched

    // Result queue
    pse_pkg::t_result              r_queue [pse_pkg::QDEPTH];
    logic [pse_pkg::QAW-1:0]       r_wr_ptr,  n_wr_ptr;
    logic [pse_pkg::QAW-1:0]       r_rd_ptr,  n_rd_ptr;
    logic [pse_pkg::QCNT_W-1:0]    r_count,   n_count;

    logic                          in_xfer;
    logic                          out_xfer;

    // next-state working values
    logic [pse_pkg::VARINT_W-1:0]  vi_part;
    logic [pse_pkg::VARINT_W-1:0]  vi_acc;
    logic                          vi_done;
    logic                          vi_bad;
    logic                          bad;
    logic                          p_vld;     // start marker or text byte
    logic [pse_pkg::KIND_W-1:0]    p_kind;
    logic                          e_vld;     // end-of-message status
    logic [pse_pkg::KIND_W-1:0]    e_kind;
    pse_pkg::t_result              ent0, ent1;
    logic [1:0]                    push_cnt;

    // ------------------------------------------------------------------
    // Handshakes. The input stalls while fewer than two queue slots are free,
    // so a byte that produces two results never overflows it. The register
    // port is always ready; the user must write it only while idle (unchecked).
    // ------------------------------------------------------------------
    assign o_stall     = (r_count > pse_pkg::QCNT_W'(pse_pkg::QDEPTH - 2));
    assign in_xfer     = i_valid && !o_stall;
    assign o_valid     = (r_count != '0);
    assign out_xfer    = o_valid && !i_stall;
    assign o_cfg_ready = 1'b1;

    assign o_kind        = r_queue[r_rd_ptr].kind;
    assign o_text_byte   = r_queue[r_rd_ptr].text_byte;
    assign o_last_of_run = r_queue[r_rd_ptr].last_of_run;

    // ------------------------------------------------------------------
    // Varint step: 7 data bits per byte, least significant group first.
    // On the fifth byte only its low four bits land inside 32 bits.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_vi_idx)
            3'd0:    vi_part = {25'b0, i_data_byte[6:0]};
            3'd1:    vi_part = {18'b0, i_data_byte[6:0], 7'b0};
            3'd2:    vi_part = {11'b0, i_data_byte[6:0], 14'b0};
            3'd3:    vi_part = {4'b0,  i_data_byte[6:0], 21'b0};
            default: vi_part = {i_data_byte[3:0], 28'b0};
        endcase
    end

    assign vi_acc  = r_acc | vi_part;
    assign vi_done = !i_data_byte[7];
    // a fifth byte that still asks for more is malformed
    assign vi_bad  = i_data_byte[7] && (r_vi_idx == pse_pkg::VI_LAST);

    // ------------------------------------------------------------------
    // Parser next state
    // ------------------------------------------------------------------
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_vi_idx    = r_vi_idx;
        n_rem       = r_rem;
        n_is_wanted = r_is_wanted;
        n_err       = r_err;
        bad         = r_err;
        p_vld       = 1'b0;
        p_kind      = pse_pkg::KIND_START;
        e_vld       = 1'b0;
        e_kind      = pse_pkg::KIND_OK;

        if (!r_err) begin
            if (r_phase == pse_pkg::PH_PAYLOAD) begin
                if (r_is_wanted) begin
                    p_vld  = 1'b1;
                    p_kind = pse_pkg::KIND_TEXT;
                end
                if (r_rem != '0) begin
                    n_rem = r_rem - pse_pkg::VARINT_W'(1);
                end
                if (n_rem == '0) begin
                    n_phase = pse_pkg::PH_KEY;
                end
            end else if (vi_bad) begin
                bad = 1'b1;
            end else if (!vi_done) begin
                n_acc    = vi_acc;
                n_vi_idx = r_vi_idx + pse_pkg::VI_IDX_W'(1);
            end else begin
                // varint complete
                n_acc    = '0;
                n_vi_idx = '0;
                case (r_phase)
                    pse_pkg::PH_KEY: begin
                        if (vi_acc[2:0] == pse_pkg::WT_VARINT) begin
                            n_phase = pse_pkg::PH_SKIPVAR;
                        end else if (vi_acc[2:0] == pse_pkg::WT_LEN) begin
                            n_is_wanted = (vi_acc[31:3] == r_wanted_field);
                            n_phase     = pse_pkg::PH_LEN;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    pse_pkg::PH_LEN: begin
                        n_rem = vi_acc;
                        if (r_is_wanted) begin
                            p_vld  = 1'b1;
                            p_kind = pse_pkg::KIND_START;
                        end
                        n_phase = (vi_acc != '0) ? pse_pkg::PH_PAYLOAD : pse_pkg::PH_KEY;
                    end
                    default: begin
                        // skipped varint value done
                        n_phase = pse_pkg::PH_KEY;
                    end
                endcase
            end
        end

        if (i_end_of_message) begin
            e_vld  = 1'b1;
            e_kind = (bad || n_phase != pse_pkg::PH_KEY || n_vi_idx != '0) ?
                     pse_pkg::KIND_ERR : pse_pkg::KIND_OK;
        end

        // end of message or a fresh error: back to the start-of-field state
        if (i_end_of_message || bad) begin
            n_phase     = pse_pkg::PH_KEY;
            n_acc       = '0;
            n_vi_idx    = '0;
            n_rem       = '0;
            n_is_wanted = 1'b0;
            n_err       = bad && !i_end_of_message;
        end
    end

    // ------------------------------------------------------------------
    // Results of this byte, packed in order into up to two queue slots
    // ------------------------------------------------------------------
    always_comb begin
        ent0.kind        = p_vld ? p_kind : e_kind;
        ent0.text_byte   = (p_vld && p_kind == pse_pkg::KIND_TEXT) ? i_data_byte : '0;
        ent0.last_of_run = !(p_vld && e_vld);
        ent1.kind        = e_kind;
        ent1.text_byte   = '0;
        ent1.last_of_run = 1'b1;
        push_cnt         = in_xfer ? ({1'b0, p_vld} + {1'b0, e_vld}) : 2'd0;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr + pse_pkg::QAW'(push_cnt);
        n_rd_ptr = r_rd_ptr + pse_pkg::QAW'(out_xfer);
        n_count  = r_count + pse_pkg::QCNT_W'(push_cnt) - pse_pkg::QCNT_W'(out_xfer);
    end

    // queue storage: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= ent0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + pse_pkg::QAW'(1)] <= ent1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_field <= pse_pkg::WANTED_FIELD_RST;
            r_phase        <= pse_pkg::PH_KEY;
            r_acc          <= '0;
            r_vi_idx       <= '0;
            r_rem          <= '0;
            r_is_wanted    <= 1'b0;
            r_err          <= 1'b0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wanted_field <= i_cfg_data;
            end
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_vi_idx    <= n_vi_idx;
                r_rem       <= n_rem;
                r_is_wanted <= n_is_wanted;
                r_err       <= n_err;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTH
    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pse_pkg::QCNT_W'(pse_pkg::QDEPTH))
        else $error("result queue overflow");

    // end of message always leaves the parser at a clean field boundary
    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_end_of_message |=>
        r_phase == pse_pkg::PH_KEY && r_vi_idx == '0 && !r_err && r_rem == '0)
        else $error("parser not cleared after end of message");

    // while an error is latched the parse state sits at reset values
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_phase == pse_pkg::PH_KEY && r_vi_idx == '0 && !r_is_wanted)
        else $error("parse state active with error latched");

    // payload phase always has bytes left to consume
    a_payload_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pse_pkg::PH_PAYLOAD |-> r_rem != '0)
        else $error("payload phase with no bytes remaining");
`endif

endmodule
